// ===== design/wpst_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint pair sweep tracer package
// Shared types, codes and sizes for the tracer and its sub-blocks.
// ----------------------------------------------------------------------------
package wpst_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IndexBits  = 6;
  localparam int unsigned CoordBits  = 32;
  localparam int unsigned StepBits   = 31;
  localparam int unsigned SumBits    = 66;
  localparam int unsigned RootBits   = 34;
  localparam int unsigned ProdBits   = 64;
  localparam int unsigned RemBits    = 36;
  localparam int unsigned QuotBits   = 32;

  localparam logic [6:0] MaxCount  = 7'd64;
  localparam logic [5:0] RootSteps = 6'd34;
  localparam logic [5:0] QuotSteps = 6'd32;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_STEP_X      = 2'd1,
    REG_STEP_Y      = 2'd2,
    REG_STEP_Z      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } point_t;

  typedef struct packed {
    logic start;
    logic is_root;
  } unit_op_t;

endpackage

// ===== design/waypoint_pair_sweep_tracer.sv =====
// A restart reports once the first pair is fetched; a tick after the distance root and
// three axis quotients, first fetching the next leg if the point arrives, and after the root
// alone if the distance is zero. With no points in use the result comes in the cycle after
// acceptance. Loads and mode 3 return nothing. A new item is taken in the cycle after a
// result or a load. The shared shift-subtract unit runs 34 steps per root, 32 per quotient.
// Synchronous reset clears sweep state, position, goal, point count; results cannot stall.
// ----------------------------------------------------------------------------
// Waypoint pair sweep tracer
// Moves a point at a fixed step between every ordered pair of waypoints.
// ----------------------------------------------------------------------------
module waypoint_pair_sweep_tracer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             mode,
  input  logic [wpst_pkg::IndexBits-1:0]         point_index,
  input  logic signed [wpst_pkg::CoordBits-1:0]  point_x,
  input  logic signed [wpst_pkg::CoordBits-1:0]  point_y,
  input  logic signed [wpst_pkg::CoordBits-1:0]  point_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [wpst_pkg::StepBits-1:0]          cfg_data,
  output logic                                   done,
  output logic signed [wpst_pkg::CoordBits-1:0]  pos_x,
  output logic signed [wpst_pkg::CoordBits-1:0]  pos_y,
  output logic signed [wpst_pkg::CoordBits-1:0]  pos_z,
  output logic [wpst_pkg::IndexBits-1:0]         from_index,
  output logic [wpst_pkg::IndexBits-1:0]         to_index,
  output logic                                   return_leg
);
  import wpst_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_FETCH_A   = 15'h0002,
    S_FETCH_B   = 15'h0004,
    S_FETCH_C   = 15'h0008,
    S_DELTA     = 15'h0010,
    S_SQ_MUL    = 15'h0020,
    S_SQ_ACC    = 15'h0040,
    S_ROOT      = 15'h0080,
    S_ROOT_WAIT = 15'h0100,
    S_CHECK     = 15'h0200,
    S_SC_MUL    = 15'h0400,
    S_SC_DIV    = 15'h0800,
    S_SC_WAIT   = 15'h1000,
    S_SC_ADD    = 15'h2000,
    S_DONE      = 15'h4000
  } state_t;

  state_t state;

  logic [6:0]                  point_count;
  logic [StepBits-1:0]         steps [3];
  logic [IndexBits-1:0]        pair_first;
  logic [IndexBits-1:0]        pair_second;
  logic                        leg;
  logic signed [CoordBits-1:0] cur [3];
  logic signed [CoordBits-1:0] goal [3];
  logic [CoordBits-1:0]        mag [3];
  logic                        neg [3];
  logic [1:0]                  axis;
  logic [SumBits-1:0]          sum_sq;
  logic [RootBits-1:0]         root_dist;
  logic [ProdBits-1:0]         prod;
  logic                        snapped;
  logic                        tick_op;
  logic [IndexBits-1:0]        fetch_cur;
  logic [IndexBits-1:0]        fetch_goal;

  logic [6:0]           cnt;
  logic                 accept;
  logic                 table_we;
  point_t               table_wdata;
  logic [IndexBits-1:0] table_raddr;
  point_t               table_rdata;
  unit_op_t             unit_op;
  logic                 unit_done;
  logic [RootBits-1:0]  unit_result;
  logic [CoordBits-1:0] mul_a;
  logic [CoordBits-1:0] mul_b;
  logic [ProdBits-1:0]  mul_p;
  logic [6:0]           s1;
  logic [6:0]           s2;
  logic [6:0]           f1;
  logic                 wrap;
  logic [IndexBits-1:0] next_first;
  logic [IndexBits-1:0] next_second;
  logic signed [33:0]   move_sum;
  logic signed [33:0]   move_step;
  logic signed [CoordBits-1:0] move_sat;
  logic signed [32:0]   diff [3];

  assign cnt       = (point_count > MaxCount) ? MaxCount : point_count;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign table_we    = accept && (mode == MODE_LOAD);
  assign table_wdata = '{x: point_x, y: point_y, z: point_z};
  assign table_raddr = (state == S_FETCH_A) ? fetch_cur : fetch_goal;

  wpst_table u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (point_index),
    .wdata (table_wdata),
    .raddr (table_raddr),
    .rdata (table_rdata)
  );

  assign unit_op.start   = (state == S_ROOT) || (state == S_SC_DIV);
  assign unit_op.is_root = (state == S_ROOT);

  wpst_root_div u_root_div (
    .clk      (clk),
    .rst      (rst),
    .op       (unit_op),
    .radicand (sum_sq),
    .dividend (prod),
    .divisor  (root_dist),
    .done     (unit_done),
    .result   (unit_result)
  );

  assign mul_a = mag[axis];
  assign mul_b = (state == S_SC_MUL) ? {1'b0, steps[axis]} : mag[axis];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {goal[i][CoordBits-1], goal[i]} - {cur[i][CoordBits-1], cur[i]};
    end
  end

  always_comb begin
    s1 = {1'b0, pair_second} + 7'd1;
    s2 = (s1 == {1'b0, pair_first}) ? s1 + 7'd1 : s1;
    f1 = {1'b0, pair_first} + 7'd1;
    wrap = (s2 >= cnt);
    next_second = wrap ? '0 : s2[IndexBits-1:0];
    if (wrap) begin
      next_first = (f1 >= cnt) ? '0 : f1[IndexBits-1:0];
    end else begin
      next_first = pair_first;
    end
  end

  always_comb begin
    move_step = neg[axis] ? -$signed({2'b00, unit_result[QuotBits-1:0]})
                          : $signed({2'b00, unit_result[QuotBits-1:0]});
    move_sum  = {{2{cur[axis][CoordBits-1]}}, cur[axis]} + move_step;
    if (move_sum[33:31] == 3'b000 || move_sum[33:31] == 3'b111) begin
      move_sat = move_sum[CoordBits-1:0];
    end else if (move_sum[33]) begin
      move_sat = 32'sh8000_0000;
    end else begin
      move_sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      steps[0]    <= 31'd3277;
      steps[1]    <= 31'd3277;
      steps[2]    <= 31'd3277;
      pair_first  <= '0;
      pair_second <= 6'd1;
      leg         <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur[i]  <= '0;
        goal[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_POINT_COUNT: point_count <= cfg_data[6:0];
          REG_STEP_X:      steps[0] <= cfg_data;
          REG_STEP_Y:      steps[1] <= cfg_data;
          REG_STEP_Z:      steps[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode_t'(mode))
              MODE_RESTART: begin
                if (cnt != 7'd0) begin
                  pair_first  <= '0;
                  pair_second <= (cnt > 7'd1) ? 6'd1 : 6'd0;
                  leg         <= 1'b0;
                  fetch_cur   <= '0;
                  fetch_goal  <= (cnt > 7'd1) ? 6'd1 : 6'd0;
                  tick_op     <= 1'b0;
                  state       <= S_FETCH_A;
                end else begin
                  state <= S_DONE;
                end
              end
              MODE_TICK: begin
                snapped <= 1'b0;
                state   <= (cnt != 7'd0) ? S_DELTA : S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_FETCH_A: state <= S_FETCH_B;
        S_FETCH_B: begin
          cur[0] <= table_rdata.x;
          cur[1] <= table_rdata.y;
          cur[2] <= table_rdata.z;
          state  <= S_FETCH_C;
        end
        S_FETCH_C: begin
          goal[0] <= table_rdata.x;
          goal[1] <= table_rdata.y;
          goal[2] <= table_rdata.z;
          state   <= tick_op ? S_DELTA : S_DONE;
        end
        S_DELTA: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= diff[i][32];
            mag[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][CoordBits-1:0];
          end
          sum_sq <= '0;
          axis   <= 2'd0;
          state  <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          prod  <= mul_p;
          state <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          sum_sq <= sum_sq + {2'b00, prod};
          if (axis == 2'd2) begin
            state <= S_ROOT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_ROOT: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (unit_done) begin
            root_dist <= unit_result;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          axis <= 2'd0;
          if (!snapped && (root_dist < {3'b000, steps[0]})) begin
            snapped <= 1'b1;
            tick_op <= 1'b1;
            state   <= S_FETCH_A;
            if (!leg) begin
              leg        <= 1'b1;
              fetch_cur  <= pair_second;
              fetch_goal <= pair_first;
            end else begin
              leg         <= 1'b0;
              pair_first  <= next_first;
              pair_second <= next_second;
              fetch_cur   <= next_first;
              fetch_goal  <= next_second;
            end
          end else if (root_dist != '0) begin
            state <= S_SC_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_SC_MUL: begin
          prod  <= mul_p;
          state <= S_SC_DIV;
        end
        S_SC_DIV: state <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (unit_done) begin
            state <= S_SC_ADD;
          end
        end
        S_SC_ADD: begin
          cur[axis] <= move_sat;
          if (axis == 2'd2) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_SC_MUL;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done       = (state == S_DONE);
  assign pos_x      = cur[0];
  assign pos_y      = cur[1];
  assign pos_z      = cur[2];
  assign from_index = pair_first;
  assign to_index   = pair_second;
  assign return_leg = leg;

endmodule

// ===== design/wpst_table.sv =====
// ----------------------------------------------------------------------------
// Waypoint table
// Single write port, single registered read port holding all three axes.
// ----------------------------------------------------------------------------
module wpst_table (
  input  logic                            clk,
  input  logic                            we,
  input  logic [wpst_pkg::IndexBits-1:0]  waddr,
  input  wpst_pkg::point_t                wdata,
  input  logic [wpst_pkg::IndexBits-1:0]  raddr,
  output wpst_pkg::point_t                rdata
);
  import wpst_pkg::*;

  point_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wpst_root_div.sv =====
// ----------------------------------------------------------------------------
// Shared shift-subtract unit
// Computes an integer square root two bits a step, or a quotient one bit a
// step, with the same compare and subtract.
// ----------------------------------------------------------------------------
module wpst_root_div (
  input  logic                           clk,
  input  logic                           rst,
  input  wpst_pkg::unit_op_t             op,
  input  logic [wpst_pkg::SumBits-1:0]   radicand,
  input  logic [wpst_pkg::ProdBits-1:0]  dividend,
  input  logic [wpst_pkg::RootBits-1:0]  divisor,
  output logic                           done,
  output logic [wpst_pkg::RootBits-1:0]  result
);
  import wpst_pkg::*;

  logic [RemBits-1:0]  rem;
  logic [RootBits-1:0] acc;
  logic [67:0]         src;
  logic [5:0]          count;
  logic                active;
  logic                root_mode;
  logic [RemBits+1:0]  rem_sh;
  logic [RemBits+1:0]  trial;
  logic [RemBits+1:0]  diff;
  logic                fits;

  always_comb begin
    if (root_mode) begin
      rem_sh = {rem, src[67:66]};
      trial  = {2'b00, acc, 2'b01};
    end else begin
      rem_sh = {1'b0, rem, src[67]};
      trial  = {4'b0000, divisor};
    end
    fits = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (op.start) begin
        active    <= 1'b1;
        root_mode <= op.is_root;
        acc       <= '0;
        if (op.is_root) begin
          count <= RootSteps;
          rem   <= '0;
          src   <= {2'b00, radicand};
        end else begin
          count <= QuotSteps;
          rem   <= {4'b0000, dividend[63:32]};
          src   <= {dividend[31:0], 36'd0};
        end
      end else if (active) begin
        rem   <= fits ? diff[RemBits-1:0] : rem_sh[RemBits-1:0];
        acc   <= {acc[RootBits-2:0], fits};
        src   <= root_mode ? {src[65:0], 2'b00} : {src[66:0], 1'b0};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule
